[src/jtl_pkg.sv]
`timescale 1ns / 1ps

package jtl_pkg;

  // Longest lexeme the counter tracks before it saturates.
  localparam int MAX_LEXEME = 1023;
  localparam int LexW       = $clog2(MAX_LEXEME + 1);
  // Width of the line counter.
  localparam int LINE_BITS  = 16;
  // Characters kept of a bare word; enough for the longest keyword.
  localparam int WORD_DEPTH = 5;
  localparam int WordIdxW   = $clog2(WORD_DEPTH);
  // Result queue depth; one input item can push two results.
  localparam int RES_DEPTH  = 4;
  localparam int ResPtrW    = $clog2(RES_DEPTH);
  localparam int ResCntW    = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [31:0] WORD_TRUE  = "True";
  localparam logic [31:0] WORD_NULL  = "null";
  localparam logic [39:0] WORD_FALSE = "False";

  typedef enum logic [3:0] {
    TOK_LBRACE  = 4'd0,
    TOK_RBRACE  = 4'd1,
    TOK_LBRACK  = 4'd2,
    TOK_RBRACK  = 4'd3,
    TOK_COLON   = 4'd4,
    TOK_COMMA   = 4'd5,
    TOK_TEXT    = 4'd6,
    TOK_KEY     = 4'd7,
    TOK_NUM     = 4'd8,
    TOK_LITERAL = 4'd9,
    TOK_EOF     = 4'd10,
    TOK_ERROR   = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_CHAR   = 2'd1,
    ERR_WORD   = 2'd2,
    ERR_STRING = 2'd3
  } err_e;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_STRING = 6'b000010,
    MODE_AFTER  = 6'b000100,
    MODE_NUMBER = 6'b001000,
    MODE_WORD   = 6'b010000,
    MODE_ERROR  = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    kind_e       token_kind;
    logic [9:0]  token_length;
    logic [15:0] line_number;
    err_e        error_code;
    logic        last_result;
  } out_t;

  // Results of one lexer step on their way into the result queue.
  typedef struct packed {
    logic [1:0] count;
    out_t       res0;
    out_t       res1;
  } push_t;

  function automatic logic [9:0] clip_len(input logic [LexW-1:0] cnt);
    logic [31:0] w;
    w = 32'(cnt);
    return (w > 32'd1023) ? 10'd1023 : w[9:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

endpackage

[src/jtl_core.sv]
`timescale 1ns / 1ps

module jtl_core import jtl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  in_t   item_i,
  output push_t push_o
);

  mode_e                mode_q, mode_d;
  logic [LexW-1:0]      cnt_q, cnt_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic                 dot_q, dot_d;
  logic [7:0]           word_q [WORD_DEPTH];
  logic [7:0]           word_d [WORD_DEPTH];

  logic [7:0]      c;
  logic            eoi;
  logic [LexW-1:0] cnt_up;
  logic            word_bool;

  logic  idle_emit;
  kind_e idle_kind;
  err_e  idle_err;
  mode_e idle_mode;

  logic       use_idle;
  logic [1:0] n_res;
  kind_e      kind0, kind1;
  logic [9:0] len0, len1;
  err_e       err0, err1;

  assign c      = item_i.char_in;
  assign eoi    = item_i.end_of_input;
  assign cnt_up = (cnt_q < LexW'(MAX_LEXEME)) ? cnt_q + LexW'(1) : cnt_q;

  assign word_bool =
      (cnt_q == LexW'(4) &&
       ({word_q[0], word_q[1], word_q[2], word_q[3]} == WORD_TRUE ||
        {word_q[0], word_q[1], word_q[2], word_q[3]} == WORD_NULL)) ||
      (cnt_q == LexW'(5) &&
       {word_q[0], word_q[1], word_q[2], word_q[3], word_q[4]} == WORD_FALSE);

  // What a character does when it starts a fresh token.
  always_comb begin
    idle_emit = 1'b0;
    idle_kind = TOK_EOF;
    idle_err  = ERR_NONE;
    idle_mode = MODE_IDLE;
    if (!is_space(c)) begin
      case (c)
        CH_LBRACE: begin idle_emit = 1'b1; idle_kind = TOK_LBRACE; end
        CH_RBRACE: begin idle_emit = 1'b1; idle_kind = TOK_RBRACE; end
        CH_LBRACK: begin idle_emit = 1'b1; idle_kind = TOK_LBRACK; end
        CH_RBRACK: begin idle_emit = 1'b1; idle_kind = TOK_RBRACK; end
        CH_COLON:  begin idle_emit = 1'b1; idle_kind = TOK_COLON;  end
        CH_COMMA:  begin idle_emit = 1'b1; idle_kind = TOK_COMMA;  end
        CH_QUOTE:  idle_mode = MODE_STRING;
        default: begin
          if (is_digit(c) || c == CH_DOT) begin
            idle_mode = MODE_NUMBER;
          end else if (is_alpha(c)) begin
            idle_mode = MODE_WORD;
          end else begin
            idle_emit = 1'b1;
            idle_kind = TOK_ERROR;
            idle_err  = ERR_CHAR;
            idle_mode = MODE_ERROR;
          end
        end
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    line_d   = line_q;
    dot_d    = dot_q;
    word_d   = word_q;
    use_idle = 1'b0;
    n_res    = 2'd0;
    kind0    = TOK_EOF;
    kind1    = TOK_EOF;
    len0     = '0;
    len1     = '0;
    err0     = ERR_NONE;
    err1     = ERR_NONE;

    if (mode_q != MODE_ERROR && !eoi && c == CH_LF && line_q != {LINE_BITS{1'b1}}) begin
      line_d = line_q + LINE_BITS'(1);
    end

    unique case (mode_q)
      MODE_STRING: begin
        if (eoi) begin
          n_res  = 2'd1;
          kind0  = TOK_ERROR;
          err0   = ERR_STRING;
          mode_d = MODE_ERROR;
        end else if (c == CH_QUOTE) begin
          mode_d = MODE_AFTER;
        end else begin
          cnt_d = cnt_up;
        end
      end
      MODE_AFTER: begin
        if (eoi) begin
          n_res  = 2'd2;
          kind0  = TOK_TEXT;
          len0   = clip_len(cnt_q);
          kind1  = TOK_EOF;
          mode_d = MODE_IDLE;
        end else if (is_space(c)) begin
          mode_d = MODE_AFTER;
        end else if (c == CH_COLON) begin
          n_res  = 2'd2;
          kind0  = TOK_KEY;
          len0   = clip_len(cnt_q);
          kind1  = TOK_COLON;
          mode_d = MODE_IDLE;
        end else begin
          n_res    = 2'd1;
          kind0    = TOK_TEXT;
          len0     = clip_len(cnt_q);
          use_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!eoi && is_digit(c)) begin
          cnt_d = cnt_up;
        end else if (!eoi && c == CH_DOT && !dot_q) begin
          dot_d = 1'b1;
          cnt_d = cnt_up;
        end else begin
          n_res  = 2'd1;
          kind0  = TOK_NUM;
          len0   = clip_len(cnt_q);
          mode_d = MODE_IDLE;
          if (eoi) begin
            n_res = 2'd2;
            kind1 = TOK_EOF;
          end else begin
            use_idle = 1'b1;
          end
        end
      end
      MODE_WORD: begin
        if (!eoi && (is_alpha(c) || is_digit(c))) begin
          if (cnt_q < LexW'(WORD_DEPTH)) begin
            word_d[cnt_q[WordIdxW-1:0]] = c;
          end
          cnt_d = cnt_up;
        end else if (word_bool) begin
          n_res  = 2'd1;
          kind0  = TOK_LITERAL;
          len0   = clip_len(cnt_q);
          mode_d = MODE_IDLE;
          if (eoi) begin
            n_res = 2'd2;
            kind1 = TOK_EOF;
          end else begin
            use_idle = 1'b1;
          end
        end else begin
          n_res  = 2'd1;
          kind0  = TOK_ERROR;
          err0   = ERR_WORD;
          mode_d = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
        mode_d = MODE_ERROR;
      end
      default: begin
        mode_d = MODE_IDLE;
        if (eoi) begin
          n_res = 2'd1;
          kind0 = TOK_EOF;
        end else begin
          use_idle = 1'b1;
        end
      end
    endcase

    // A fresh character lands in whichever result slot is still free.
    if (use_idle) begin
      mode_d = idle_mode;
      if (idle_mode == MODE_STRING) begin
        cnt_d = '0;
      end
      if (idle_mode == MODE_NUMBER) begin
        cnt_d = LexW'(1);
        dot_d = (c == CH_DOT);
      end
      if (idle_mode == MODE_WORD) begin
        cnt_d     = LexW'(1);
        word_d[0] = c;
      end
      if (idle_emit) begin
        if (n_res == 2'd0) begin
          n_res = 2'd1;
          kind0 = idle_kind;
          err0  = idle_err;
        end else begin
          n_res = 2'd2;
          kind1 = idle_kind;
          err1  = idle_err;
        end
      end
    end
  end

  always_comb begin
    push_o.count             = step_i ? n_res : 2'd0;
    push_o.res0.token_kind   = kind0;
    push_o.res0.token_length = len0;
    push_o.res0.line_number  = 16'(32'(line_d));
    push_o.res0.error_code   = err0;
    push_o.res0.last_result  = (n_res == 2'd1);
    push_o.res1.token_kind   = kind1;
    push_o.res1.token_length = len1;
    push_o.res1.line_number  = 16'(32'(line_d));
    push_o.res1.error_code   = err1;
    push_o.res1.last_result  = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      line_q <= LINE_BITS'(1);
      dot_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      line_q <= line_d;
      dot_q  <= dot_d;
    end
  end

  // Word characters are only read after the current word has written them.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      word_q <= word_d;
    end
  end

endmodule

[src/jtl_res_queue.sv]
`timescale 1ns / 1ps

module jtl_res_queue import jtl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  out_t                 mem_q [RES_DEPTH];
  logic [ResPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0]   cnt_q;
  logic                 pop;
  logic [ResPtrW-1:0]   wr_ptr_nx;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a full two-result step, independent of the output side.
  assign room_o      = (cnt_q <= ResCntW'(RES_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + ResPtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResPtrW'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ResPtrW'(1);
      end
      cnt_q <= cnt_q + ResCntW'(push_i.count) - ResCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

endmodule

[src/json_token_lexer.sv]
`timescale 1ns / 1ps
// Path: an accepted item waits in the input register, then the lexer step
// writes its results into the result queue; the step stalls without room.
// Throughput: one item per cycle while the queue has room for two results;
// an item's two results leave one by one; the four-entry queue sets the slack.
// Reset: asynchronous, active low; idle mode, line count one, queue empty.
module json_token_lexer import jtl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic  in_valid_q;
  in_t   in_q;
  logic  room;
  logic  step;
  push_t push;

  assign step       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  jtl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .push_o (push)
  );

  jtl_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/jtl_checker.sv]
`timescale 1ns / 1ps

module jtl_checker import jtl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A waiting input item keeps its value until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item changed while waiting");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The line count starts at one and never wraps to zero.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.line_number != 16'd0)
    else $error("line number of zero");

  // Only error tokens carry an error code, and they always carry one.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.token_kind == TOK_ERROR) ==
                     (out_data_o.error_code != ERR_NONE)))
    else $error("error code does not match token kind");

  // Punctuation, eof and error tokens have no length.
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind != TOK_TEXT &&
    out_data_o.token_kind != TOK_KEY && out_data_o.token_kind != TOK_NUM &&
    out_data_o.token_kind != TOK_LITERAL |-> out_data_o.token_length == 10'd0)
    else $error("nonzero length on a token without a lexeme");

endmodule

bind json_token_lexer jtl_checker u_checker (.*);
